// ----- rtl/ipv4_dotted_text_parser_assert.svh -----
// Assertion macros for the dotted address text parser
`ifndef IPV4_DOTTED_TEXT_PARSER_ASSERT_SVH
`define IPV4_DOTTED_TEXT_PARSER_ASSERT_SVH

// same-cycle implication, held off during reset
`define IPV4P_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("ipv4 parser: check failed");

// next-cycle implication, held off during reset
`define IPV4P_ASSERT_NXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("ipv4 parser: check failed");

`endif

// ----- rtl/ipv4p_pkg.sv -----
// Types and constants shared by the dotted address text parser
`timescale 1ns / 1ps
`default_nettype none

package ipv4p_pkg;

  localparam int unsigned MIN_TEXT_LEN    = 7;
  localparam int unsigned MAX_FIELD_CHARS = 10;
  localparam int unsigned OCTET_MAX       = 255;
  localparam int unsigned FIELD_COUNT     = 4;

  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] ASCII_NINE = 8'd57;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_LEN   = 3'd1,
    ST_NON_DIGIT = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_OVER_255  = 3'd4,
    ST_COUNT     = 3'd5
  } status_t;

  // running state of the field being parsed
  typedef struct packed {
    logic [8:0]      value;
    logic [3:0]      digits;
    logic [2:0]      total;
    logic [3:0][7:0] store;
    status_t         err;
  } field_state_t;

  typedef struct packed {
    logic [3:0][7:0] octets;
    status_t         status;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/ipv4p_core.sv -----
// Per-character state update and result generation for the address parser
`timescale 1ns / 1ps
`default_nettype none

module ipv4p_core #(
  parameter int unsigned MAX_TEXT_LEN = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic [7:0]          character,
  input  wire logic                last,
  output ipv4p_pkg::result_t       res
);

  localparam int unsigned CW = $clog2(MAX_TEXT_LEN + 2);

  logic [CW-1:0]           text_count;
  logic [CW-1:0]           text_count_next;
  logic                    text_ended;
  logic                    text_ended_next;
  ipv4p_pkg::field_state_t fs;
  ipv4p_pkg::field_state_t fs_next;
  ipv4p_pkg::field_state_t fs_upd;
  ipv4p_pkg::field_state_t fs_fin;
  logic [11:0]             acc;
  logic [3:0]              digit;

  function automatic ipv4p_pkg::field_state_t close_field(ipv4p_pkg::field_state_t f);
    ipv4p_pkg::field_state_t r;
    r = f;
    if (f.digits != 4'd0 && f.err == ipv4p_pkg::ST_OK) begin
      if (f.digits > 4'(ipv4p_pkg::MAX_FIELD_CHARS)) begin
        r.err = ipv4p_pkg::ST_TOO_LONG;
      end else if (f.value > 9'(ipv4p_pkg::OCTET_MAX)) begin
        r.err = ipv4p_pkg::ST_OVER_255;
      end else begin
        // fifth field counts but is not stored
        if (f.total < 3'(ipv4p_pkg::FIELD_COUNT)) begin
          r.store[f.total[1:0]] = f.value[7:0];
        end
        if (f.total < 3'(ipv4p_pkg::FIELD_COUNT + 1)) begin
          r.total = f.total + 3'd1;
        end
      end
    end
    r.value  = '0;
    r.digits = '0;
    return r;
  endfunction

  always_comb begin
    digit = 4'(character - ipv4p_pkg::ASCII_ZERO);
    acc   = 12'({fs.value, 3'b000}) + 12'({fs.value, 1'b0}) + {8'd0, digit};

    if (text_count < CW'(MAX_TEXT_LEN + 1)) begin
      text_count_next = text_count + CW'(1);
    end else begin
      text_count_next = text_count;
    end

    fs_upd          = fs;
    text_ended_next = text_ended;
    if (!text_ended) begin
      if (character == ipv4p_pkg::CHAR_NUL) begin
        fs_upd          = close_field(fs);
        text_ended_next = 1'b1;
      end else if (character == ipv4p_pkg::CHAR_DOT) begin
        fs_upd = close_field(fs);
      end else begin
        if (fs.digits < 4'(ipv4p_pkg::MAX_FIELD_CHARS + 1)) begin
          fs_upd.digits = fs.digits + 4'd1;
        end
        if (character >= ipv4p_pkg::ASCII_ZERO && character <= ipv4p_pkg::ASCII_NINE) begin
          // saturate one above the octet limit
          if (acc > 12'(ipv4p_pkg::OCTET_MAX + 1)) begin
            fs_upd.value = 9'(ipv4p_pkg::OCTET_MAX + 1);
          end else begin
            fs_upd.value = acc[8:0];
          end
        end else if (fs.err == ipv4p_pkg::ST_OK) begin
          fs_upd.err = ipv4p_pkg::ST_NON_DIGIT;
        end
      end
    end

    fs_fin = close_field(fs_upd);

    if (text_count_next < CW'(ipv4p_pkg::MIN_TEXT_LEN)
        || text_count_next > CW'(MAX_TEXT_LEN)) begin
      res.status = ipv4p_pkg::ST_BAD_LEN;
    end else if (fs_fin.err != ipv4p_pkg::ST_OK) begin
      res.status = fs_fin.err;
    end else if (fs_fin.total != 3'(ipv4p_pkg::FIELD_COUNT)) begin
      res.status = ipv4p_pkg::ST_COUNT;
    end else begin
      res.status = ipv4p_pkg::ST_OK;
    end
    res.octets = (res.status == ipv4p_pkg::ST_OK) ? fs_fin.store : '0;

    fs_next = fs_upd;
    if (last) begin
      fs_next         = '0;
      text_count_next = '0;
      text_ended_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_count <= '0;
      text_ended <= 1'b0;
      fs         <= '0;
    end else if (step) begin
      text_count <= text_count_next;
      text_ended <= text_ended_next;
      fs         <= fs_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ipv4_dotted_text_parser.sv -----
// IPv4 dotted-decimal text parser: one request per character, one result per text.
// Takes one character per cycle and sustains one request every cycle. A request
// passes an input register, then a single state update that also forms the
// result into the output register, so the result of a text is registered there as
// its last character leaves the input register. A failing result carries zero octets.
// The output register lets the next text start while a result waits to be taken;
// only a last character waits, for as long as the previous result is not taken.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_dotted_text_parser #(
  parameter int unsigned MAX_TEXT_LEN = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] character
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata    // [2:0] status, [10:3] octet_first,
                                      // [18:11] octet_second, [26:19] octet_third,
                                      // [34:27] octet_fourth, [39:35] zero
);

  logic               in_valid;
  logic [7:0]         in_char;
  logic               in_last;
  logic               advance;
  ipv4p_pkg::result_t res;

  // a last character may only move on when the result register can take it
  assign advance  = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  ipv4p_core #(
    .MAX_TEXT_LEN(MAX_TEXT_LEN)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .character (in_char),
    .last      (in_last),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      m_tdata <= {5'd0, res.octets, res.status};
    end
  end

`include "ipv4_dotted_text_parser_assert.svh"

  `IPV4P_ASSERT_IMP(a_fail_zero, clk, rst,
    m_tvalid && m_tdata[2:0] != 3'(ipv4p_pkg::ST_OK), m_tdata[34:3] == 32'd0)
  `IPV4P_ASSERT_IMP(a_status_range, clk, rst,
    m_tvalid, m_tdata[2:0] <= 3'(ipv4p_pkg::ST_COUNT) && m_tdata[39:35] == 5'd0)
  `IPV4P_ASSERT_NXT(a_last_gives_result, clk, rst, advance && in_last, m_tvalid)
  `IPV4P_ASSERT_IMP(a_stall_holds_input, clk, rst,
    in_valid && in_last && m_tvalid && !m_tready, !s_tready)

endmodule

`default_nettype wire

// ----- tb/tb_ipv4_dotted_text_parser.sv -----
// Self-checking bench for the dotted address text parser: directed texts, then random traffic
`timescale 1ns / 1ps
`default_nettype none

module tb_ipv4_dotted_text_parser;

  localparam int unsigned TEXT_MAX = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 10;

  typedef enum int {
    SHAPE_GOOD,
    SHAPE_COUNT,
    SHAPE_CORRUPT,
    SHAPE_BIG,
    SHAPE_LONG,
    SHAPE_NOISE,
    SHAPE_CUT
  } text_shape_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tready = 1'b0;
  wire logic   s_tready;
  wire logic   m_tvalid;
  wire logic [39:0] m_tdata;

  ipv4_dotted_text_parser #(
    .MAX_TEXT_LEN(TEXT_MAX)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #2 clk = ~clk;

  // traffic shaping, percent of cycles
  int gap_pct = 0;
  int stall_pct = 0;

  int fail_count = 0;
  int chars_taken = 0;
  int texts_sent = 0;
  int results_seen = 0;
  int cycle_count = 0;

  logic [7:0]          text_buf[$];
  ipv4p_pkg::result_t  pending_addrs[$];

  // parser state mirror
  logic [5:0] txt_len = '0;
  logic [8:0] fld_val = '0;
  logic [3:0] fld_chars = '0;
  logic [2:0] fld_cnt = '0;
  logic [3:0][7:0] octet_buf = '0;
  logic       nul_seen = 1'b0;
  ipv4p_pkg::status_t first_fault = ipv4p_pkg::ST_OK;

  function automatic void clear_text();
    txt_len = '0;
    fld_val = '0;
    fld_chars = '0;
    fld_cnt = '0;
    octet_buf = '0;
    nul_seen = 1'b0;
    first_fault = ipv4p_pkg::ST_OK;
  endfunction

  // a field is judged when it closes: length first, then value
  function automatic void close_field();
    if (fld_chars != 0 && first_fault == ipv4p_pkg::ST_OK) begin
      if (fld_chars > ipv4p_pkg::MAX_FIELD_CHARS) begin
        first_fault = ipv4p_pkg::ST_TOO_LONG;
      end else if (fld_val > ipv4p_pkg::OCTET_MAX) begin
        first_fault = ipv4p_pkg::ST_OVER_255;
      end else begin
        if (fld_cnt < ipv4p_pkg::FIELD_COUNT) octet_buf[fld_cnt[1:0]] = fld_val[7:0];
        if (fld_cnt < ipv4p_pkg::FIELD_COUNT + 1) fld_cnt = fld_cnt + 1'b1;
      end
    end
    fld_val = '0;
    fld_chars = '0;
  endfunction

  function automatic void parse_char(input logic [7:0] ch, input logic fin);
    int unsigned        acc;
    ipv4p_pkg::result_t res;
    if (txt_len < TEXT_MAX + 1) txt_len = txt_len + 1'b1;
    if (!nul_seen) begin
      if (ch == ipv4p_pkg::CHAR_NUL) begin
        close_field();
        nul_seen = 1'b1;
      end else if (ch == ipv4p_pkg::CHAR_DOT) begin
        close_field();
      end else begin
        if (fld_chars < ipv4p_pkg::MAX_FIELD_CHARS + 1) fld_chars = fld_chars + 1'b1;
        if (ch >= ipv4p_pkg::ASCII_ZERO && ch <= ipv4p_pkg::ASCII_NINE) begin
          acc = 32'(fld_val) * 10 + 32'(ch - ipv4p_pkg::ASCII_ZERO);
          if (acc > ipv4p_pkg::OCTET_MAX + 1) acc = ipv4p_pkg::OCTET_MAX + 1;
          fld_val = acc[8:0];
        end else if (first_fault == ipv4p_pkg::ST_OK) begin
          first_fault = ipv4p_pkg::ST_NON_DIGIT;
        end
      end
    end
    if (fin) begin
      close_field();
      if (txt_len < ipv4p_pkg::MIN_TEXT_LEN || txt_len > TEXT_MAX)
        res.status = ipv4p_pkg::ST_BAD_LEN;
      else if (first_fault != ipv4p_pkg::ST_OK) res.status = first_fault;
      else if (fld_cnt != ipv4p_pkg::FIELD_COUNT) res.status = ipv4p_pkg::ST_COUNT;
      else res.status = ipv4p_pkg::ST_OK;
      res.octets = (res.status == ipv4p_pkg::ST_OK) ? octet_buf : '0;
      pending_addrs.push_back(res);
      clear_text();
    end
  endfunction

  // request side monitor feeds the predictor
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      chars_taken <= chars_taken + 1;
      parse_char(s_tdata, s_tlast);
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    ipv4p_pkg::result_t want;
    ipv4p_pkg::result_t got;
    if (!rst && m_tvalid && m_tready) begin
      results_seen <= results_seen + 1;
      got = m_tdata[34:0];
      if (pending_addrs.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
        fail_count++;
      end else begin
        want = pending_addrs.pop_front();
        if (got.status != want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          fail_count++;
        end
        for (int k = 0; k < 4; k++) begin
          if (got.octets[k] !== want.octets[k]) begin
            $display("%0t: octet %0d expected %0d actual %0d", $time, k,
                     want.octets[k], got.octets[k]);
            fail_count++;
          end
        end
        if (m_tdata[39:35] !== 5'd0) begin
          $display("%0t: pad bits expected 0 actual %b", $time, m_tdata[39:35]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d results outstanding", $time,
               pending_addrs.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] ch, input logic fin);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) send_char(text_buf[i], i == text_buf.size() - 1);
    texts_sent++;
  endtask

  function automatic void push_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  task automatic send_str(input string s);
    text_buf.delete();
    push_str(s);
    send_text();
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending_addrs.size() != 0);
  endtask

  function automatic void build_address(input int nf, input int big_idx, input int long_idx);
    int v;
    text_buf.delete();
    if ($urandom_range(4) == 0)
      repeat ($urandom_range(1, 2)) text_buf.push_back(ipv4p_pkg::CHAR_DOT);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) begin
        text_buf.push_back(ipv4p_pkg::CHAR_DOT);
        if ($urandom_range(6) == 0) text_buf.push_back(ipv4p_pkg::CHAR_DOT);
      end
      if (f == long_idx) begin
        repeat ($urandom_range(11, 13))
          text_buf.push_back(ipv4p_pkg::ASCII_ZERO + 8'($urandom_range(9)));
      end else begin
        case ($urandom_range(2))
          0: v = $urandom_range(9);
          1: v = $urandom_range(99);
          default: v = $urandom_range(255);
        endcase
        if (f == big_idx) v = $urandom_range(256, 99999);
        if ($urandom_range(9) == 0)
          repeat ($urandom_range(1, 2)) text_buf.push_back(ipv4p_pkg::ASCII_ZERO);
        push_str($sformatf("%0d", v));
      end
    end
    if ($urandom_range(7) == 0) text_buf.push_back(ipv4p_pkg::CHAR_DOT);
    if ($urandom_range(5) == 0) begin
      text_buf.push_back(ipv4p_pkg::CHAR_NUL);
      repeat ($urandom_range(3)) text_buf.push_back(8'($urandom_range(255)));
    end
  endfunction

  function automatic void random_text();
    text_shape_t shape;
    int r;
    int keep;
    r = $urandom_range(99);
    if (r < 55) shape = SHAPE_GOOD;
    else if (r < 63) shape = SHAPE_COUNT;
    else if (r < 71) shape = SHAPE_CORRUPT;
    else if (r < 78) shape = SHAPE_BIG;
    else if (r < 85) shape = SHAPE_LONG;
    else if (r < 93) shape = SHAPE_NOISE;
    else shape = SHAPE_CUT;
    case (shape)
      SHAPE_COUNT: build_address($urandom_range(1) ? 3 : 5, -1, -1);
      SHAPE_BIG:   build_address(4, $urandom_range(3), -1);
      SHAPE_LONG:  build_address(4, -1, $urandom_range(3));
      SHAPE_NOISE: begin
        text_buf.delete();
        repeat ($urandom_range(1, 24)) begin
          r = $urandom_range(9);
          if (r < 5) text_buf.push_back(8'($urandom_range(255)));
          else if (r < 8) text_buf.push_back(ipv4p_pkg::ASCII_ZERO + 8'($urandom_range(9)));
          else text_buf.push_back(ipv4p_pkg::CHAR_DOT);
        end
      end
      default: build_address(4, -1, -1);
    endcase
    if (shape == SHAPE_CORRUPT)
      text_buf[$urandom_range(text_buf.size() - 1)] = 8'($urandom_range(255));
    if (shape == SHAPE_CUT) begin
      keep = $urandom_range(1, text_buf.size());
      while (text_buf.size() > keep) void'(text_buf.pop_back());
    end
  endfunction

  task automatic test_well_formed();
    send_str("0.0.0.0");
    send_str("255.255.255.255");
    send_str("001.002.003.255");
    send_str("..10.20.30.40..");
    send_str("10.200.30.40....");  // full length, no terminator
    // text after a terminator only counts toward the length
    text_buf.delete();
    push_str("1.2.3.4");
    text_buf.push_back(ipv4p_pkg::CHAR_NUL);
    text_buf.push_back(8'hFF);
    push_str("z9");
    send_text();
  endtask

  task automatic test_length_limits();
    send_str("7");
    send_str("1.2.3");
    send_str("1.2.3.4.5.6.7.8.9");
    send_str("1.2.3.4.1.2.3.4.1.2.3.4.1.2.3.4.1.2.3.4.");
    text_buf.delete();
    text_buf.push_back(ipv4p_pkg::CHAR_NUL);
    push_str("abcdef");
    send_text();
  endtask

  task automatic test_field_faults();
    send_str("1.2.a.4");
    text_buf.delete();
    push_str("1.2.3.");
    text_buf.push_back(8'hC8);
    send_text();
    send_str("1.2.00000000001");
    send_str("1.2.3.256");
    send_str("1.2.3.99999");
    send_str("1.2.3.4.5");
    send_str("1.300.x.4");
    send_str("1.2.x4567890123");  // bad character beats the field length
  endtask

  task automatic test_random_mix(input int send_idle, input int recv_stall, input int n_chars);
    int sent;
    sent = 0;
    gap_pct = send_idle;
    stall_pct = recv_stall;
    while (sent < n_chars) begin
      random_text();
      sent += text_buf.size();
      send_text();
    end
  endtask

  // sender holds off until every outstanding result is back
  task automatic test_hold_until_drained();
    gap_pct = 28;
    stall_pct = 28;
    repeat (4) begin
      random_text();
      send_text();
      s_tvalid <= 1'b0;
      wait_drained();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_well_formed();
    test_length_limits();
    test_field_faults();
    test_random_mix(0, 0, 200);
    test_random_mix(58, 0, 200);
    test_hold_until_drained();
    test_random_mix(0, 58, 200);
    test_random_mix(28, 28, 200);
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d texts (%0d characters), %0d results checked, %0d mismatches.",
             texts_sent, chars_taken, results_seen, fail_count);
    $display("Covered good, short, long, malformed and noisy texts under four traffic mixes.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/ipv4p_pkg.sv
rtl/ipv4p_core.sv
rtl/ipv4_dotted_text_parser.sv
tb/tb_ipv4_dotted_text_parser.sv
